// ----- hw/rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes of the positional list engine
// Request and response payloads, operation and status codes, and the
// command that the core hands to every storage cell.
// ----------------------------------------------------------------------------
package ple_pkg;

   // operation codes of a request
   localparam logic [2:0] OP_READ      = 3'd0;
   localparam logic [2:0] OP_INSERT    = 3'd1;
   localparam logic [2:0] OP_REMOVE    = 3'd2;
   localparam logic [2:0] OP_POP_HEAD  = 3'd3;
   localparam logic [2:0] OP_POP_BACK  = 3'd4;
   localparam logic [2:0] OP_REVERSE   = 3'd5;

   // status codes of a response
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [6:0]  position;
      logic [31:0] value_in;
   } ple_req_type;

   typedef struct packed {
      logic [31:0] value_out;
      logic [1:0]  status;
      logic [6:0]  entry_count;
   } ple_rsp_type;

   // shift command broadcast to the cell chain
   typedef struct packed {
      logic ins;   // open a gap at the target cell and write into it
      logic del;   // close the gap at the target cell
   } ple_cmd_type;

endpackage

// ----- hw/rtl/positional_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_core: bounded ordered list of data words
// Requests read, insert, remove, pop front, pop back or reverse the list by
// logical position; each one gives exactly one response.
// ----------------------------------------------------------------------------
// Use:
//   req channel: req_valid / req_stall / req_data (operation, position,
//     value_in). A transfer happens when req_valid is high and req_stall low.
//   rsp channel: rsp_valid / rsp_stall / rsp_data (value_out, status,
//     entry_count), one response per request, in request order.
//   Latency: the response is valid in the cycle after the request transfer.
//   Throughput: one request per cycle while the response is not stalled.
//     No operation takes extra steps: the row of CAPACITY cells shifts all
//     entries at once; reverse only flips the position-to-cell direction flag.
//   Stall: the response sits in the output register; while it is stalled,
//     req_stall is raised, otherwise a new request is taken in the same
//     cycle as the response transfer.
//   Reset: the list is empty and in normal order. Cell contents are not
//     cleared; only cells below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_core import ple_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ple_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ple_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

   // control state
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             rev_ff,    rev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ple_rsp_type      rsp_ff,    rsp_in;

   logic             accept;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic [CMP_W-1:0] lpos;
   logic [CMP_W-1:0] cell_x;
   logic             in_range;
   logic             ins_range;
   logic             full;
   logic             empty;
   logic             take;
   logic             ok_read;
   ple_cmd_type      cmd;
   logic [IDX_W-1:0] tgt;
   logic [1:0]       status;
   logic [63:0]      din_wide;
   logic [DATA_WIDTH-1:0] din;
   logic [DATA_WIDTH-1:0] rd_any;
   logic [63:0]      rd_wide;

   logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_vec  [CAPACITY];

   // handshake: one output register between the two sides
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   assign pos_x     = CMP_W'(req_data.position);
   assign cnt_x     = CMP_W'(count_ff);
   assign in_range  = (pos_x < cnt_x);
   assign ins_range = (pos_x <= cnt_x);
   assign full      = (cnt_x == CAP_X);
   assign empty     = (cnt_x == '0);

   // data word masked to the stored width
   assign din_wide = 64'(req_data.value_in);
   assign din      = din_wide[DATA_WIDTH-1:0];

   // decode: status, logical position, and whether an entry leaves
   always_comb begin
      status  = ST_OK;
      lpos    = '0;
      take    = 1'b0;
      ok_read = 1'b0;
      cmd     = '0;
      unique case (req_data.operation)
         OP_READ: begin
            lpos    = pos_x;
            if (!in_range) status = ST_RANGE;
            else           ok_read = 1'b1;
         end
         OP_INSERT: begin
            lpos = pos_x;
            if (!ins_range) status = ST_RANGE;
            else if (full)  status = ST_FULL;
            else            cmd.ins = accept;
         end
         OP_REMOVE: begin
            lpos = pos_x;
            if (!in_range) status = ST_RANGE;
            else           take = 1'b1;
         end
         OP_POP_HEAD: begin
            lpos = '0;
            if (empty) status = ST_EMPTY;
            else       take = 1'b1;
         end
         OP_POP_BACK: begin
            lpos = cnt_x - CMP_W'(1);
            if (empty) status = ST_EMPTY;
            else       take = 1'b1;
         end
         default: begin
         end
      endcase
      cmd.del = accept & take;
   end

   // logical position to cell: mirrored when the list is reversed
   always_comb begin
      if (req_data.operation == OP_INSERT)
         cell_x = rev_ff ? (cnt_x - lpos) : lpos;
      else
         cell_x = rev_ff ? (cnt_x - CMP_W'(1) - lpos) : lpos;
   end
   assign tgt = cell_x[IDX_W-1:0];

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_q[i+1];
      end
      ple_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .tgt        (tgt),
         .wr_data    (din),
         .left_data  (left_d),
         .right_data (right_d),
         .hold_data  (cell_q[i]),
         .rd_data    (rd_vec[i])
      );
   end

   // read bus: only the target cell drives a nonzero word
   always_comb begin
      rd_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_any = rd_any | rd_vec[i];
      end
   end
   assign rd_wide = 64'(rd_any);

   // next count, direction and response
   always_comb begin
      count_in = count_ff;
      rev_in   = rev_ff;
      rsp_in   = rsp_ff;
      if (accept) begin
         if (cmd.ins)      count_in = count_ff + CNT_W'(1);
         else if (cmd.del) count_in = count_ff - CNT_W'(1);
         if (req_data.operation == OP_REVERSE) rev_in = ~rev_ff;
         rsp_in.value_out = (ok_read || take) ? rd_wide[31:0] : 32'd0;
         rsp_in.status    = status;
         rsp_in.entry_count = 7'(CMP_W'(count_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CAP_X)
      else $error("entry count above capacity");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins && cmd.del))
      else $error("insert and delete shift in the same cycle");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.entry_count == 7'(CMP_W'(count_ff)))
      else $error("reported count differs from list count");

   a_flag_status: assert property (@(posedge clock) disable iff (reset)
      accept && status != ST_OK |=> count_ff == $past(count_ff))
      else $error("flagged request changed the list");

endmodule

// ----- hw/rtl/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list chain
// Holds one data word. On insert the target takes the new word and the cells
// above it their left neighbor; on delete the target and the cells above it
// take their right neighbor. The target drives its word onto the read bus.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int IDX_W      = 6,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  ple_cmd_type           cmd,
   input  logic [IDX_W-1:0]      tgt,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] hold_data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] cell_ff;
   logic [DATA_WIDTH-1:0] cell_in;
   logic                  at_tgt;
   logic                  above_tgt;

   assign at_tgt    = (MY_IDX == tgt);
   assign above_tgt = (MY_IDX > tgt);

   // shift by one place toward the back on insert, toward the front on delete
   always_comb begin
      cell_in = cell_ff;
      if (cmd.ins) begin
         if (at_tgt)         cell_in = wr_data;
         else if (above_tgt) cell_in = left_data;
      end else if (cmd.del) begin
         if (at_tgt || above_tgt) cell_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign hold_data = cell_ff;
   assign rd_data   = at_tgt ? cell_ff : '0;

endmodule

// ----- tb/sv/list_response_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_response_checker: response checker of the positional list engine
// Watches both channels of the core. Every request transfer runs through a
// local model of the list and queues the response it must give; every
// response transfer is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module list_response_checker import ple_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  ple_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  ple_rsp_type rsp_data,
   output int          mismatch_count,
   output int          pending_count,
   output int          list_fill
);

   // list contents in logical order, front at index 0
   logic [31:0] words [CAPACITY];
   ple_rsp_type expected_rsp [$];

   // take out the word at a logical position and close the gap
   function automatic logic [31:0] take_word(input int pos);
      logic [31:0] w;
      int          i;
      w = words[pos];
      for (i = pos; i + 1 < list_fill; i++) begin
         words[i] = words[i + 1];
      end
      list_fill--;
      return w;
   endfunction

   // update the list for one request and return the response it gives
   function automatic ple_rsp_type apply_list_request(input ple_req_type r);
      ple_rsp_type o;
      int          pos;
      int          i;
      logic [31:0] w;
      o   = '0;
      pos = r.position;
      case (r.operation)
         OP_READ: begin
            if (pos >= list_fill) o.status = ST_RANGE;
            else o.value_out = words[pos];
         end
         OP_INSERT: begin
            // range check wins over the full check
            if (pos > list_fill) begin
               o.status = ST_RANGE;
            end else if (list_fill >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               for (i = list_fill; i > pos; i--) begin
                  words[i] = words[i - 1];
               end
               words[pos] = r.value_in;
               list_fill++;
            end
         end
         OP_REMOVE: begin
            if (pos >= list_fill) o.status = ST_RANGE;
            else o.value_out = take_word(pos);
         end
         OP_POP_HEAD: begin
            if (list_fill == 0) o.status = ST_EMPTY;
            else o.value_out = take_word(0);
         end
         OP_POP_BACK: begin
            if (list_fill == 0) o.status = ST_EMPTY;
            else o.value_out = take_word(list_fill - 1);
         end
         OP_REVERSE: begin
            for (i = 0; i < list_fill / 2; i++) begin
               w                        = words[i];
               words[i]                 = words[list_fill - 1 - i];
               words[list_fill - 1 - i] = w;
            end
         end
         default: begin
            // unused codes leave the list alone
         end
      endcase
      o.entry_count = list_fill[6:0];
      return o;
   endfunction

   // responses first: a response and a new request may share one edge
   always @(posedge clock) begin
      ple_rsp_type want;
      if (reset) begin
         list_fill      = 0;
         mismatch_count = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t: response expected none got %h", $time, rsp_data);
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               if (rsp_data.value_out !== want.value_out) begin
                  mismatch_count++;
                  $display("%0t: value_out expected %h got %h",
                           $time, want.value_out, rsp_data.value_out);
               end
               if (rsp_data.status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  mismatch_count++;
                  $display("%0t: entry_count expected %0d got %0d",
                           $time, want.entry_count, rsp_data.entry_count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(apply_list_request(req_data));
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

// ----- tb/sv/tb_positional_list_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_core: stimulus and verdict for the list engine
// Runs a directed pass over the corner cases, fills the list to capacity
// under a long response hold-off, then random traffic in three idling
// modes. The response checker beside the core reports the mismatches.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_core;
   import ple_pkg::*;

   localparam int CAPACITY = 64;
   // operation codes the core does not define
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ple_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   ple_rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int list_fill;
   int send_idle_pct;
   int recv_idle_pct;
   logic hold_req;   // toggled to start one long hold-off

   always #2 clock = ~clock;

   positional_list_engine_core #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(32)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   list_response_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count),
      .list_fill     (list_fill)
   );

   // run limit
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: random stalls, or a long hold-off counted down here
   initial begin
      logic hold_seen;
      int   long_hold;
      hold_seen = 1'b0;
      long_hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req !== hold_seen) begin
            hold_seen = hold_req;
            long_hold = 80;
         end
         if (long_hold > 0) begin
            rsp_stall <= 1'b1;
            long_hold--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic ple_req_type make_req(input logic [2:0] op, input logic [6:0] pos,
                                            input logic [31:0] val);
      ple_req_type r;
      r.operation = op;
      r.position  = pos;
      r.value_in  = val;
      return r;
   endfunction

   // random request; insert share steers the list to grow or shrink
   function automatic ple_req_type pick_request(input int ins_pct, input int fill);
      ple_req_type r;
      int          k;
      k = $urandom_range(99);
      if ($urandom_range(99) < ins_pct) r.operation = OP_INSERT;
      else if (k < 35) r.operation = OP_READ;
      else if (k < 65) r.operation = OP_REMOVE;
      else if (k < 77) r.operation = OP_POP_HEAD;
      else if (k < 89) r.operation = OP_POP_BACK;
      else if (k < 97) r.operation = OP_REVERSE;
      else if (k[0])   r.operation = OP_UNUSED_A;
      else             r.operation = OP_UNUSED_B;
      // mostly positions near the live range, sometimes any 7-bit value
      if ($urandom_range(99) < 12) r.position = 7'($urandom_range(127));
      else r.position = 7'($urandom_range(fill));
      r.value_in = $urandom;
      return r;
   endfunction

   // one request transfer; entered and left at a falling edge
   task automatic send_request(input ple_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // hold the sender until every queued response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   task automatic random_phase(input int items);
      int n;
      for (n = 0; n < items; n++) begin
         send_request(pick_request((n / 40) % 2 == 0 ? 55 : 20, list_fill));
      end
   endtask

   initial begin
      int n;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      hold_req      = 1'b0;
      send_idle_pct = 18;
      recv_idle_pct = 70;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list corners
      send_request(make_req(OP_READ, 7'd0, 32'h1111_1111));
      send_request(make_req(OP_POP_HEAD, 7'd0, 32'h0));
      send_request(make_req(OP_POP_BACK, 7'd0, 32'h0));
      send_request(make_req(OP_REMOVE, 7'd0, 32'h0));
      send_request(make_req(OP_REVERSE, 7'd0, 32'h0));
      send_request(make_req(OP_INSERT, 7'd1, 32'hDEAD_BEEF));
      // one entry, then reversed inserts and reads
      send_request(make_req(OP_INSERT, 7'd0, 32'hFFFF_FFFF));
      send_request(make_req(OP_REVERSE, 7'd0, 32'h0));
      send_request(make_req(OP_INSERT, 7'd1, 32'h0000_0000));
      send_request(make_req(OP_INSERT, 7'd1, 32'hA5A5_A5A5));
      send_request(make_req(OP_READ, 7'd0, 32'h0));
      send_request(make_req(OP_READ, 7'd2, 32'h0));
      send_request(make_req(OP_READ, 7'd3, 32'h0));
      send_request(make_req(OP_READ, 7'd127, 32'h0));
      send_request(make_req(OP_REMOVE, 7'd1, 32'h0));
      send_request(make_req(OP_UNUSED_A, 7'd0, 32'h0));
      send_request(make_req(OP_UNUSED_B, 7'd127, 32'hFFFF_FFFF));
      send_request(make_req(OP_REVERSE, 7'd0, 32'h0));
      send_request(make_req(OP_INSERT, 7'd64, 32'h5A5A_5A5A));
      send_request(make_req(OP_POP_HEAD, 7'd0, 32'h0));
      send_request(make_req(OP_POP_BACK, 7'd0, 32'h0));
      send_request(make_req(OP_POP_BACK, 7'd0, 32'h0));
      drain_responses();

      // fill to capacity while the response side holds off for a while
      hold_req = ~hold_req;
      while (list_fill < CAPACITY) begin
         send_request(make_req(OP_INSERT, 7'($urandom_range(list_fill)), $urandom));
      end
      send_request(make_req(OP_INSERT, 7'd64, $urandom));
      send_request(make_req(OP_INSERT, 7'd0, $urandom));
      send_request(make_req(OP_INSERT, 7'd65, $urandom));
      send_request(make_req(OP_REVERSE, 7'd0, 32'h0));
      send_request(make_req(OP_READ, 7'd63, 32'h0));
      send_request(make_req(OP_READ, 7'd64, 32'h0));
      send_request(make_req(OP_REMOVE, 7'd63, 32'h0));
      send_request(make_req(OP_INSERT, 7'd63, 32'h8000_0001));
      drain_responses();

      random_phase(160);
      drain_responses();

      send_idle_pct = 70;
      recv_idle_pct = 18;
      random_phase(160);
      drain_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(160);

      // wait out the last responses and the output register
      drain_responses();
      for (n = 0; n < 5; n++) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- positional_list_engine_core.f -----
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine_core.sv
tb/sv/list_response_checker.sv
tb/sv/tb_positional_list_engine_core.sv
